@@ src/text_console_glyph_renderer_macros.svh @@
// ----------------------------------------------------------------------------
// Text console glyph renderer: assertion macros
// Shared property macros; every module that uses them has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types, constants and the 5x7 font table of the text console renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcgr_pkg;

  // Defaults of the top level parameters.
  localparam int COORD_BITS_DEF  = 13;
  localparam int MAX_SCALE_DEF   = 8;
  localparam int GLYPH_COUNT_DEF = 42;

  // Fixed widths.
  localparam int CHAR_BITS       = 8;
  localparam int COLOR_BITS      = 24;
  localparam int DIM_BITS        = 13;
  localparam int SCALE_REG_BITS  = 4;
  localparam int CURSOR_X_BITS   = 16;
  localparam int CURSOR_Y_BITS   = 14;
  localparam int ARITH_BITS      = 17;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 24;
  localparam int FONT_INDEX_BITS = 6;
  localparam int COUNT_CMP_BITS  = 9;

  // Font geometry.
  localparam int FONT_ROWS   = 42;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FG_COLOR      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BG_COLOR      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHAR_SCALE    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd4;

  // Register reset values.
  localparam logic [COLOR_BITS-1:0]     FG_RESET     = 24'hFFFFFF;
  localparam logic [COLOR_BITS-1:0]     BG_RESET     = 24'h000000;
  localparam logic [SCALE_REG_BITS-1:0] SCALE_RESET  = 4'd1;
  localparam logic [DIM_BITS-1:0]       WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0]       HEIGHT_RESET = 13'd480;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] CHAR_TAB        = 8'h09;
  localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CHAR_RETURN     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_BANG       = 8'h21;
  localparam logic [CHAR_BITS-1:0] CHAR_DASH       = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_PERIOD     = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CHAR_COLON      = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_0    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_9    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CHAR_CASE_SHIFT = 8'h20;

  // Font table positions.
  localparam logic [FONT_INDEX_BITS-1:0] FONT_SPACE      = 6'd0;
  localparam logic [FONT_INDEX_BITS-1:0] FONT_PERIOD     = 6'd1;
  localparam logic [FONT_INDEX_BITS-1:0] FONT_COLON      = 6'd2;
  localparam logic [FONT_INDEX_BITS-1:0] FONT_DASH       = 6'd3;
  localparam logic [FONT_INDEX_BITS-1:0] FONT_UNDERSCORE = 6'd4;
  localparam logic [FONT_INDEX_BITS-1:0] FONT_BANG       = 6'd5;
  localparam logic [CHAR_BITS-1:0]       FONT_DIGIT_BASE = 8'd6;
  localparam logic [CHAR_BITS-1:0]       FONT_UPPER_BASE = 8'd16;

  // Result kinds.
  localparam logic KIND_FILL   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef enum logic [1:0] {
    CLS_GLYPH,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_TAB
  } char_class_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CR,
    OP_TAB,
    OP_NEWLINE,
    OP_SCROLL,
    OP_MASK_STEP,
    OP_MASK_BUILD,
    OP_EMIT_SCROLL,
    OP_SCAN,
    OP_ADVANCE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        wrap_need;
    logic        bottom_need;
    logic        step_last;
    logic        scroll_pend;
    logic        mask_any;
    logic        mask_head;
    logic        out_free;
  } dp_status_t;

  function automatic char_class_t char_class(input logic [CHAR_BITS-1:0] c);
    char_class_t cls;
    if (c == CHAR_NEWLINE) begin
      cls = CLS_NEWLINE;
    end else if (c == CHAR_RETURN) begin
      cls = CLS_RETURN;
    end else if (c == CHAR_TAB) begin
      cls = CLS_TAB;
    end else begin
      cls = CLS_GLYPH;
    end
    return cls;
  endfunction

  // Font row of a character, with lower case folded; unknown codes map to space.
  function automatic logic [FONT_INDEX_BITS-1:0] font_index(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0]       u;
    logic [FONT_INDEX_BITS-1:0] idx;
    u = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      u = c - CHAR_CASE_SHIFT;
    end
    idx = FONT_SPACE;
    if (u == CHAR_PERIOD) begin
      idx = FONT_PERIOD;
    end else if (u == CHAR_COLON) begin
      idx = FONT_COLON;
    end else if (u == CHAR_DASH) begin
      idx = FONT_DASH;
    end else if (u == CHAR_UNDERSCORE) begin
      idx = FONT_UNDERSCORE;
    end else if (u == CHAR_BANG) begin
      idx = FONT_BANG;
    end else if (u >= CHAR_DIGIT_0 && u <= CHAR_DIGIT_9) begin
      idx = FONT_INDEX_BITS'(u - CHAR_DIGIT_0 + FONT_DIGIT_BASE);
    end else if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
      idx = FONT_INDEX_BITS'(u - CHAR_UPPER_A + FONT_UPPER_BASE);
    end
    return idx;
  endfunction

  // Glyph bitmap, top row first; within a row the leftmost pixel is the MSB.
  function automatic logic [GLYPH_BITS-1:0] font_bits(input logic [FONT_INDEX_BITS-1:0] idx);
    logic [GLYPH_BITS-1:0] g;
    case (idx)
      6'd1:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      6'd2:  g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00};
      6'd3:  g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00};
      6'd4:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h00};
      6'd5:  g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h00};
      6'd6:  g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd7:  g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd8:  g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd9:  g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      6'd10: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd11: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd12: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd13: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd14: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd15: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      6'd16: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd17: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      6'd18: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      6'd19: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      6'd20: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      6'd21: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd22: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      6'd23: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd24: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd25: g = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      6'd26: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd27: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd28: g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      6'd29: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      6'd30: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd31: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd32: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd33: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      6'd34: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd35: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd36: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd37: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd38: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      6'd39: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      6'd40: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd41: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ src/tcgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer that steps the datapath through one character at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_glyph_renderer_macros.svh"

module tcgr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcgr_pkg::dp_status_t status,
  output tcgr_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_NL_CHECK,
    S_WRAP_CHECK,
    S_BOTTOM_CHECK,
    S_MASK,
    S_BUILD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd.op       = tcgr_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.op       = tcgr_pkg::OP_LOAD;
          state_nxt    = S_DISPATCH;
          in_ready_nxt = 1'b0;
        end
      end
      S_DISPATCH: begin
        unique case (status.cls)
          tcgr_pkg::CLS_NEWLINE: begin
            cmd.op    = tcgr_pkg::OP_NEWLINE;
            state_nxt = S_NL_CHECK;
          end
          tcgr_pkg::CLS_RETURN: begin
            cmd.op       = tcgr_pkg::OP_CR;
            state_nxt    = S_IDLE;
            in_ready_nxt = 1'b1;
          end
          tcgr_pkg::CLS_TAB: begin
            cmd.op       = tcgr_pkg::OP_TAB;
            state_nxt    = S_IDLE;
            in_ready_nxt = 1'b1;
          end
          tcgr_pkg::CLS_GLYPH: begin
            if (status.wrap_need) begin
              cmd.op    = tcgr_pkg::OP_NEWLINE;
              state_nxt = S_WRAP_CHECK;
            end else begin
              state_nxt = S_BOTTOM_CHECK;
            end
          end
        endcase
      end
      S_NL_CHECK: begin
        if (status.bottom_need) begin
          cmd.op = tcgr_pkg::OP_SCROLL;
        end
        state_nxt = S_EMIT;
      end
      S_WRAP_CHECK: begin
        if (status.bottom_need) begin
          cmd.op = tcgr_pkg::OP_SCROLL;
        end
        state_nxt = S_BOTTOM_CHECK;
      end
      S_BOTTOM_CHECK: begin
        if (status.bottom_need) begin
          cmd.op = tcgr_pkg::OP_SCROLL;
        end
        state_nxt = S_MASK;
      end
      S_MASK: begin
        cmd.op = tcgr_pkg::OP_MASK_STEP;
        if (status.step_last) begin
          state_nxt = S_BUILD;
        end
      end
      S_BUILD: begin
        cmd.op    = tcgr_pkg::OP_MASK_BUILD;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.scroll_pend) begin
          if (status.out_free) begin
            cmd.op = tcgr_pkg::OP_EMIT_SCROLL;
          end
        end else if (status.mask_any) begin
          if (!status.mask_head || status.out_free) begin
            cmd.op = tcgr_pkg::OP_SCAN;
          end
        end else begin
          if (status.cls == tcgr_pkg::CLS_GLYPH) begin
            cmd.op = tcgr_pkg::OP_ADVANCE;
          end
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  `TCGR_ASSERT_NOW(a_ready_only_idle, in_ready_r, state_r == S_IDLE, "ready outside idle")
  `TCGR_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready_r,
                    state_r == S_DISPATCH && !in_ready_r, "accept did not start work")
  `TCGR_ASSERT_NOW(a_scroll_slot_free, cmd.op == tcgr_pkg::OP_EMIT_SCROLL, status.out_free,
                   "scroll issued into a full output register")

endmodule

@@ src/tcgr_dp.sv @@
// ----------------------------------------------------------------------------
// tcgr_dp
// Configuration, cursor, glyph clipping mask and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_glyph_renderer_macros.svh"

module tcgr_dp #(
  parameter int COORD_BITS  = tcgr_pkg::COORD_BITS_DEF,
  parameter int MAX_SCALE   = tcgr_pkg::MAX_SCALE_DEF,
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tcgr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [tcgr_pkg::CHAR_BITS-1:0]        in_char_code,
  input  tcgr_pkg::dp_cmd_t                     cmd,
  output tcgr_pkg::dp_status_t                  status,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_op_kind,
  output logic [COORD_BITS-1:0]                 out_rect_x,
  output logic [COORD_BITS-1:0]                 out_rect_y,
  output logic [COORD_BITS-1:0]                 out_rect_width,
  output logic [COORD_BITS-1:0]                 out_rect_height,
  output logic [tcgr_pkg::COLOR_BITS-1:0]       out_fill_color,
  output logic                                  out_last
);

  localparam int SCALE_BITS = $clog2(MAX_SCALE + 1);
  localparam int OFF_BITS   = $clog2(6 * MAX_SCALE + 1);
  localparam int AB         = tcgr_pkg::ARITH_BITS;
  localparam int GB         = tcgr_pkg::GLYPH_BITS;
  localparam int NC         = tcgr_pkg::GLYPH_COLS;
  localparam int NR         = tcgr_pkg::GLYPH_ROWS;

  // Configuration registers.
  logic [tcgr_pkg::COLOR_BITS-1:0]     fg_r, bg_r;
  logic [tcgr_pkg::SCALE_REG_BITS-1:0] scale_r;
  logic [tcgr_pkg::DIM_BITS-1:0]       width_r, height_r;

  // Cursor and per-character work registers.
  logic [tcgr_pkg::CURSOR_X_BITS-1:0] cx_r;
  logic [tcgr_pkg::CURSOR_Y_BITS-1:0] cy_r;
  logic [tcgr_pkg::CHAR_BITS-1:0]     char_r;
  logic [2:0]                         step_r;
  logic [OFF_BITS-1:0]                off_r;
  logic [NC-1:0]                      col_ok_r;
  logic [NR-1:0]                      row_ok_r;
  logic [GB-1:0]                      mask_r;
  logic [2:0]                         col_idx_r;
  logic [OFF_BITS-1:0]                col_off_r, row_off_r;
  logic [1:0]                         scroll_cnt_r;

  // Output register.
  logic                            out_valid_r, out_kind_r, out_last_r;
  logic [COORD_BITS-1:0]           out_x_r, out_y_r, out_w_r, out_h_r;
  logic [tcgr_pkg::COLOR_BITS-1:0] out_color_r;

  logic [4:0]            scale_ext, scale_clamp;
  logic [SCALE_BITS-1:0] s_eff;
  logic [AB-1:0]         s_a, line_a, s5_a, s6_a, s7_a, s24_a;
  logic [AB-1:0]         w_a, h_a, cx_a, cy_a, off_a;
  logic [AB-1:0]         band_y_a, band_h_a;
  logic [AB-1:0]         px_a, py_a, pw_a, ph_a;
  logic [AB-1:0]         tab_sum_a, adv_sum_a;
  logic                  col_ok_now, row_ok_now;
  logic [tcgr_pkg::FONT_INDEX_BITS-1:0] font_idx_raw, font_idx;
  logic [GB-1:0]         glyph, mask_build;
  logic                  load_scroll, load_pix, out_free;

  always_comb begin
    scale_ext = {1'b0, scale_r};
    if (scale_r == '0) begin
      scale_clamp = 5'd1;
    end else if (scale_ext > 5'(MAX_SCALE)) begin
      scale_clamp = 5'(MAX_SCALE);
    end else begin
      scale_clamp = scale_ext;
    end
    s_eff = SCALE_BITS'(scale_clamp);
  end

  assign s_a    = AB'(s_eff);
  assign line_a = s_a << 3;
  assign s5_a   = (s_a << 2) + s_a;
  assign s6_a   = s5_a + s_a;
  assign s7_a   = line_a - s_a;
  assign s24_a  = (line_a << 1) + line_a;

  // A zero screen dimension behaves as one pixel.
  assign w_a   = (width_r == '0) ? AB'(1) : AB'(width_r);
  assign h_a   = (height_r == '0) ? AB'(1) : AB'(height_r);
  assign cx_a  = AB'(cx_r);
  assign cy_a  = AB'(cy_r);
  assign off_a = AB'(off_r);

  assign col_ok_now = (cx_a + off_a) < w_a;
  assign row_ok_now = (cy_a + off_a) < h_a;

  // Scroll band: the bottom text line, or the whole screen if that is taller.
  assign band_y_a = (h_a > line_a) ? h_a - line_a : '0;
  assign band_h_a = (h_a > line_a) ? line_a : h_a;

  assign px_a = cx_a + AB'(col_off_r);
  assign py_a = cy_a + AB'(row_off_r);
  assign pw_a = (px_a + s_a > w_a) ? w_a - px_a : s_a;
  assign ph_a = (py_a + s_a > h_a) ? h_a - py_a : s_a;

  assign tab_sum_a = cx_a + s24_a;
  assign adv_sum_a = cx_a + s6_a;

  assign font_idx_raw = tcgr_pkg::font_index(char_r);
  assign font_idx = (tcgr_pkg::COUNT_CMP_BITS'(font_idx_raw) <
                     tcgr_pkg::COUNT_CMP_BITS'(GLYPH_COUNT)) ? font_idx_raw
                                                             : tcgr_pkg::FONT_SPACE;
  assign glyph = tcgr_pkg::font_bits(font_idx);

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int k = 0; k < NC; k++) begin
        mask_build[GB-1-(r*NC+k)] = glyph[GB-1-(r*NC+k)] & row_ok_r[r] & col_ok_r[k];
      end
    end
  end

  assign out_free    = !out_valid_r || out_ready;
  assign load_scroll = (cmd.op == tcgr_pkg::OP_EMIT_SCROLL);
  assign load_pix    = (cmd.op == tcgr_pkg::OP_SCAN) && mask_r[GB-1];

  assign status.cls         = tcgr_pkg::char_class(char_r);
  assign status.wrap_need   = (cx_a + s5_a) > w_a;
  assign status.bottom_need = (cy_a + s7_a) > h_a;
  assign status.step_last   = (step_r == 3'(NR - 1));
  assign status.scroll_pend = (scroll_cnt_r != '0);
  assign status.mask_any    = (mask_r != '0);
  assign status.mask_head   = mask_r[GB-1];
  assign status.out_free    = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r         <= tcgr_pkg::FG_RESET;
      bg_r         <= tcgr_pkg::BG_RESET;
      scale_r      <= tcgr_pkg::SCALE_RESET;
      width_r      <= tcgr_pkg::WIDTH_RESET;
      height_r     <= tcgr_pkg::HEIGHT_RESET;
      cx_r         <= '0;
      cy_r         <= '0;
      scroll_cnt_r <= '0;
      mask_r       <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcgr_pkg::REG_FG_COLOR:      fg_r     <= cfg_data;
          tcgr_pkg::REG_BG_COLOR:      bg_r     <= cfg_data;
          tcgr_pkg::REG_CHAR_SCALE:    scale_r  <= cfg_data[tcgr_pkg::SCALE_REG_BITS-1:0];
          tcgr_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_data[tcgr_pkg::DIM_BITS-1:0];
          tcgr_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_data[tcgr_pkg::DIM_BITS-1:0];
          default: ;
        endcase
      end

      // A new result takes the slot; otherwise an accepted one frees it.
      if (load_scroll || load_pix) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (cmd.op)
        tcgr_pkg::OP_LOAD: begin
          char_r       <= in_char_code;
          scroll_cnt_r <= '0;
          mask_r       <= '0;
          step_r       <= '0;
          off_r        <= '0;
        end
        tcgr_pkg::OP_CR: begin
          cx_r <= '0;
        end
        tcgr_pkg::OP_TAB: begin
          cx_r <= tab_sum_a[AB-1] ? '1 : tab_sum_a[tcgr_pkg::CURSOR_X_BITS-1:0];
        end
        tcgr_pkg::OP_NEWLINE: begin
          cx_r <= '0;
          cy_r <= tcgr_pkg::CURSOR_Y_BITS'(cy_a + line_a);
        end
        tcgr_pkg::OP_SCROLL: begin
          cy_r <= (cy_a >= line_a) ? tcgr_pkg::CURSOR_Y_BITS'(cy_a - line_a) : '0;
          scroll_cnt_r <= scroll_cnt_r + 2'd1;
        end
        tcgr_pkg::OP_MASK_STEP: begin
          row_ok_r <= {row_ok_now, row_ok_r[NR-1:1]};
          if (step_r < 3'(NC)) begin
            col_ok_r <= {col_ok_now, col_ok_r[NC-1:1]};
          end
          step_r <= step_r + 3'd1;
          off_r  <= off_r + OFF_BITS'(s_eff);
        end
        tcgr_pkg::OP_MASK_BUILD: begin
          mask_r    <= mask_build;
          col_idx_r <= '0;
          col_off_r <= '0;
          row_off_r <= '0;
        end
        tcgr_pkg::OP_EMIT_SCROLL: begin
          scroll_cnt_r <= scroll_cnt_r - 2'd1;
          out_kind_r   <= tcgr_pkg::KIND_SCROLL;
          out_x_r      <= '0;
          out_y_r      <= COORD_BITS'(band_y_a);
          out_w_r      <= COORD_BITS'(w_a);
          out_h_r      <= COORD_BITS'(band_h_a);
          out_color_r  <= bg_r;
          out_last_r   <= (scroll_cnt_r == 2'd1) && (mask_r == '0);
        end
        tcgr_pkg::OP_SCAN: begin
          mask_r <= mask_r << 1;
          if (col_idx_r == 3'(NC - 1)) begin
            col_idx_r <= '0;
            col_off_r <= '0;
            row_off_r <= row_off_r + OFF_BITS'(s_eff);
          end else begin
            col_idx_r <= col_idx_r + 3'd1;
            col_off_r <= col_off_r + OFF_BITS'(s_eff);
          end
          if (load_pix) begin
            out_kind_r  <= tcgr_pkg::KIND_FILL;
            out_x_r     <= COORD_BITS'(px_a);
            out_y_r     <= COORD_BITS'(py_a);
            out_w_r     <= COORD_BITS'(pw_a);
            out_h_r     <= COORD_BITS'(ph_a);
            out_color_r <= fg_r;
            out_last_r  <= (mask_r[GB-2:0] == '0);
          end
        end
        tcgr_pkg::OP_ADVANCE: begin
          cx_r <= adv_sum_a[AB-1] ? '1 : adv_sum_a[tcgr_pkg::CURSOR_X_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_op_kind     = out_kind_r;
  assign out_rect_x      = out_x_r;
  assign out_rect_y      = out_y_r;
  assign out_rect_width  = out_w_r;
  assign out_rect_height = out_h_r;
  assign out_fill_color  = out_color_r;
  assign out_last        = out_last_r;

  `TCGR_ASSERT_NOW(a_load_when_free, load_scroll || load_pix, out_free,
                   "result overwrote a waiting result")
  `TCGR_ASSERT_NOW(a_scroll_cnt_bound, 1'b1, scroll_cnt_r != 2'd3, "more than two scrolls")
  `TCGR_ASSERT_NOW(a_scan_has_mask, cmd.op == tcgr_pkg::OP_SCAN, mask_r != '0,
                   "scan issued with an empty mask")

endmodule

@@ src/text_console_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer: return and tab only move the cursor; newline may also scroll.
// A glyph may wrap and scroll, then its mask is scanned one font position at a time.
// A waiting result holds only scroll and scan steps.
// Synchronous active-low reset: cursor home, registers to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block renders one character per item. A sequencer (tcgr_ctrl) walks
// the datapath (tcgr_dp) through a fixed order of steps:
//
//   1. The item is captured and classified as newline, return, tab or glyph.
//   2. Return and tab only move the cursor and produce no result.
//   3. Newline moves the cursor down one text line and, if the next line
//      does not fit, records a scroll.
//   4. A glyph first wraps the line when it would cross the right edge
//      (which may record a scroll), then records a scroll when it would
//      cross the bottom.
//   5. For a glyph, seven compare steps build the column and row visibility
//      flags from one shared offset, and one more step turns them, together
//      with the font bitmap, into a 35-bit mask of squares to draw.
//   6. Recorded scrolls are sent first, then the mask is scanned one font
//      position per cycle, top row first, left to right; each set bit
//      waits for a free output, then sends one clipped square. The scan
//      ends at an empty mask, so the last flag is known when a result loads.
//   7. The cursor advances one cell, saturating at the top of its range.
//
// The scroll results do not depend on the cursor, so they can be sent after
// the cursor has already been moved. The next item is taken while the final
// result of the previous one still waits in the output register.

module text_console_glyph_renderer #(
  parameter int COORD_BITS  = tcgr_pkg::COORD_BITS_DEF,
  parameter int MAX_SCALE   = tcgr_pkg::MAX_SCALE_DEF,
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [tcgr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // Character input.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tcgr_pkg::CHAR_BITS-1:0]      in_char_code,
  // Draw command output.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_op_kind,
  output logic [COORD_BITS-1:0]               out_rect_x,
  output logic [COORD_BITS-1:0]               out_rect_y,
  output logic [COORD_BITS-1:0]               out_rect_width,
  output logic [COORD_BITS-1:0]               out_rect_height,
  output logic [tcgr_pkg::COLOR_BITS-1:0]     out_fill_color,
  output logic                                out_last
);

  // Commands flow from the sequencer to the datapath; status flows back.
  tcgr_pkg::dp_cmd_t    cmd;
  tcgr_pkg::dp_status_t status;

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcgr_dp #(
    .COORD_BITS  (COORD_BITS),
    .MAX_SCALE   (MAX_SCALE),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_char_code    (in_char_code),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_op_kind     (out_op_kind),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_fill_color  (out_fill_color),
    .out_last        (out_last)
  );

endmodule

@@ test/tcgr_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console renderer scoreboard
// Tracks the console cursor and registers, and checks draw commands in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcgr_tb_pkg;

  import tcgr_pkg::*;

  localparam int CW = COORD_BITS_DEF;

  typedef struct packed {
    logic                  kind;
    logic [CW-1:0]         x;
    logic [CW-1:0]         y;
    logic [CW-1:0]         w;
    logic [CW-1:0]         h;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } draw_cmd_t;

  // Row 0 is the top row; bit 4 of a row is its leftmost pixel.
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  function automatic glyph_t font_pattern(input logic [CHAR_BITS-1:0] code);
    logic [CHAR_BITS-1:0] ch;
    glyph_t               g;
    ch = code;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      ch = ch - CHAR_CASE_SHIFT;
    end
    case (ch)
      ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      ":": g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00};
      "-": g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00};
      "_": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h00};
      "!": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h00};
      "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      "6": g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D": g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "J": g = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      "X": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      default: g = '0;
    endcase
    return g;
  endfunction

  class draw_cmd_scoreboard;
    logic [COLOR_BITS-1:0]     fg;
    logic [COLOR_BITS-1:0]     bg;
    logic [SCALE_REG_BITS-1:0] scale_reg;
    logic [DIM_BITS-1:0]       width_reg;
    logic [DIM_BITS-1:0]       height_reg;
    int unsigned               pen_x;
    int unsigned               pen_y;
    int unsigned               s;
    int unsigned               wd;
    int unsigned               ht;
    draw_cmd_t                 pending_cmds[$];
    int                        mismatches;
    int                        chars_seen;
    int                        cmds_checked;
    int                        scrolls_checked;
    int                        clipped_planned;

    function new();
      fg              = FG_RESET;
      bg              = BG_RESET;
      scale_reg       = SCALE_RESET;
      width_reg       = WIDTH_RESET;
      height_reg      = HEIGHT_RESET;
      pen_x           = 0;
      pen_y           = 0;
      mismatches      = 0;
      chars_seen      = 0;
      cmds_checked    = 0;
      scrolls_checked = 0;
      clipped_planned = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_FG_COLOR:      fg = val[COLOR_BITS-1:0];
        REG_BG_COLOR:      bg = val[COLOR_BITS-1:0];
        REG_CHAR_SCALE:    scale_reg = val[SCALE_REG_BITS-1:0];
        REG_SCREEN_WIDTH:  width_reg = val[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: height_reg = val[DIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    // The band is a whole text line, or the whole screen when a line is taller.
    function void push_scroll();
      int unsigned line;
      draw_cmd_t   c;
      line    = (GLYPH_ROWS + 1) * s;
      c.kind  = KIND_SCROLL;
      c.x     = '0;
      c.y     = CW'((ht > line) ? ht - line : 0);
      c.w     = CW'(wd);
      c.h     = CW'((ht > line) ? line : ht);
      c.color = bg;
      c.last  = 1'b0;
      pending_cmds.push_back(c);
      pen_y = (pen_y >= line) ? pen_y - line : 0;
    endfunction

    function void line_feed();
      pen_x = 0;
      pen_y = (pen_y + (GLYPH_ROWS + 1) * s) & ((1 << CURSOR_Y_BITS) - 1);
      if (pen_y + GLYPH_ROWS * s > ht) begin
        push_scroll();
      end
    endfunction

    function void advance(input int unsigned step);
      pen_x = (pen_x + step > (1 << CURSOR_X_BITS) - 1) ? (1 << CURSOR_X_BITS) - 1
                                                       : pen_x + step;
    endfunction

    // Works out every draw command that one character causes.
    function void note_char(input logic [CHAR_BITS-1:0] code);
      int          first;
      int          r;
      int          k;
      int unsigned x;
      int unsigned y;
      glyph_t      g;
      draw_cmd_t   c;
      first = pending_cmds.size();
      chars_seen++;
      s  = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE_DEF) ? MAX_SCALE_DEF : scale_reg;
      wd = (width_reg == 0) ? 1 : width_reg;
      ht = (height_reg == 0) ? 1 : height_reg;
      if (code == CHAR_NEWLINE) begin
        line_feed();
      end else if (code == CHAR_RETURN) begin
        pen_x = 0;
      end else if (code == CHAR_TAB) begin
        advance(4 * (GLYPH_COLS + 1) * s);
      end else begin
        if (pen_x + GLYPH_COLS * s > wd) begin
          line_feed();
        end
        if (pen_y + GLYPH_ROWS * s > ht) begin
          push_scroll();
        end
        g = font_pattern(code);
        for (r = 0; r < GLYPH_ROWS; r++) begin
          for (k = 0; k < GLYPH_COLS; k++) begin
            x = pen_x + k * s;
            y = pen_y + r * s;
            if (g[r][GLYPH_COLS-1-k] && x < wd && y < ht) begin
              c.kind  = KIND_FILL;
              c.x     = CW'(x);
              c.y     = CW'(y);
              c.w     = CW'((x + s > wd) ? wd - x : s);
              c.h     = CW'((y + s > ht) ? ht - y : s);
              c.color = fg;
              c.last  = 1'b0;
              if (c.w != s || c.h != s) begin
                clipped_planned++;
              end
              pending_cmds.push_back(c);
            end
          end
        end
        advance((GLYPH_COLS + 1) * s);
      end
      if (pending_cmds.size() > first) begin
        pending_cmds[pending_cmds.size() - 1].last = 1'b1;
      end
    endfunction

    function string describe(input draw_cmd_t c);
      return $sformatf("kind=%0d x=%0d y=%0d w=%0d h=%0d color=%06h last=%0d",
                       c.kind, c.x, c.y, c.w, c.h, c.color, c.last);
    endfunction

    function void flag(input string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endfunction

    function void check_cmd(input draw_cmd_t got);
      draw_cmd_t want;
      if (pending_cmds.size() == 0) begin
        flag({"unexpected draw command ", describe(got)});
        return;
      end
      want = pending_cmds.pop_front();
      cmds_checked++;
      if (want.kind == KIND_SCROLL) begin
        scrolls_checked++;
      end
      if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
          got.w !== want.w || got.h !== want.h || got.color !== want.color ||
          got.last !== want.last) begin
        flag({"expected ", describe(want), " got ", describe(got)});
      end
    endfunction
  endclass

endpackage

@@ test/text_console_glyph_renderer_tb.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Streams character items through the renderer under several register setups
// and checks every draw command against a cursor-tracking scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_glyph_renderer_tb;

  import tcgr_pkg::*;
  import tcgr_tb_pkg::*;

  // Longest a single character keeps the block busy with no result to show,
  // with some margin on top of the worst glyph time.
  localparam int SETTLE_CYCLES   = 64;
  // Slowest legal run is well under this, even with every stall maxed out.
  localparam int CYCLE_LIMIT     = 600000;
  localparam int LONG_HOLD       = 400;
  // Enough tabs at the largest scale to carry the cursor past the right edge.
  localparam int TAB_RUN         = 6;
  localparam int RANDOM_SETUPS   = 6;
  localparam int ITEMS_PER_SETUP = 12;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CHAR_BITS-1:0]      in_char_code = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_op_kind;
  logic [CW-1:0]             out_rect_x;
  logic [CW-1:0]             out_rect_y;
  logic [CW-1:0]             out_rect_width;
  logic [CW-1:0]             out_rect_height;
  logic [COLOR_BITS-1:0]     out_fill_color;
  logic                      out_last;

  draw_cmd_scoreboard sb;

  // Idling switches, set per phase by the stimulus process.
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit long_hold_req = 1'b0;
  int cycle_count = 0;
  int setups = 1;

  text_console_glyph_renderer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_op_kind     (out_op_kind),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_fill_color  (out_fill_color),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** text_console_glyph_renderer: FAILED **");
      $finish;
    end
  end

  // Every draw command taken at an edge goes straight to the scoreboard. All
  // testbench drives are nonblocking, so the values read here are the ones
  // that were present at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_cmd(draw_cmd_t'({out_op_kind, out_rect_x, out_rect_y, out_rect_width,
                                out_rect_height, out_fill_color, out_last}));
    end
  end

  // Receiver side. It drops out_ready in short random bursts while stalls
  // are enabled, and once on request holds it low for a long stretch so that
  // the renderer backs up and stops taking characters.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one character and returns at the edge where it is taken. The
  // valid line stays up between back-to-back items; it only drops for a gap.
  task automatic send_char(input logic [CHAR_BITS-1:0] code);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(code);
  endtask

  // Stops sending and waits until every expected draw command has come back,
  // then lets a trailing character with no output finish as well.
  task automatic park_until_done();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges. Only called while the
  // renderer is idle.
  task automatic program_regs(input logic [CFG_DATA_BITS-1:0] fg,
                              input logic [CFG_DATA_BITS-1:0] bg,
                              input logic [CFG_DATA_BITS-1:0] scale,
                              input logic [CFG_DATA_BITS-1:0] wd,
                              input logic [CFG_DATA_BITS-1:0] ht);
    logic [CFG_DATA_BITS-1:0]  vals [5];
    logic [CFG_INDEX_BITS-1:0] regs [5];
    vals = '{fg, bg, scale, wd, ht};
    regs = '{REG_FG_COLOR, REG_BG_COLOR, REG_CHAR_SCALE, REG_SCREEN_WIDTH,
             REG_SCREEN_HEIGHT};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    setups++;
  endtask

  // Scale: mostly in range, sometimes zero or above the maximum, and now and
  // then with junk in the unused upper bits of the write data.
  function automatic logic [CFG_DATA_BITS-1:0] pick_scale();
    logic [SCALE_REG_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = SCALE_REG_BITS'($urandom_range(MAX_SCALE_DEF + 1, 15));
      default: v = SCALE_REG_BITS'($urandom_range(1, MAX_SCALE_DEF));
    endcase
    return {($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'd0, v};
  endfunction

  // Screen sizes lean small so that wrapping, scrolling and clipping happen
  // often; zero and the largest size come up as well.
  function automatic logic [CFG_DATA_BITS-1:0] pick_dim();
    logic [DIM_BITS-1:0] d;
    case ($urandom_range(0, 7))
      0:       d = '0;
      1:       d = '1;
      2, 3, 4: d = DIM_BITS'($urandom_range(1, 64));
      default: d = DIM_BITS'($urandom_range(65, 900));
    endcase
    return {($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0, d};
  endfunction

  // Text-like stream: mostly letters of both cases and digits, with control
  // characters, punctuation and arbitrary bytes mixed in.
  function automatic logic [CHAR_BITS-1:0] text_char();
    logic [CHAR_BITS-1:0] punct [5];
    punct = '{CHAR_BANG, CHAR_DASH, CHAR_PERIOD, CHAR_COLON, CHAR_UNDERSCORE};
    case ($urandom_range(0, 19))
      0:       return CHAR_NEWLINE;
      1:       return CHAR_RETURN;
      2:       return CHAR_TAB;
      3:       return CHAR_BITS'($urandom_range(0, 255));
      4, 5:    return CHAR_LOWER_A + CHAR_BITS'($urandom_range(0, 25));
      6, 7:    return CHAR_DIGIT_0 + CHAR_BITS'($urandom_range(0, 9));
      8:       return punct[$urandom_range(0, 4)];
      9:       return CHAR_SPACE;
      default: return CHAR_UPPER_A + CHAR_BITS'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic run_text(input int count);
    repeat (count) send_char(text_char());
  endtask

  initial begin : stimulus
    logic [CHAR_BITS-1:0] opening [20];
    logic [CHAR_BITS-1:0] tiny [4];
    logic [CHAR_BITS-1:0] huge [5];
    sb = new();
    opening = '{"A", "z", "a", "Z", "0", "9", CHAR_SPACE, "~", 8'h00, 8'hFF, 8'h80,
                CHAR_PERIOD, CHAR_COLON, CHAR_DASH, CHAR_UNDERSCORE, CHAR_BANG,
                CHAR_TAB, CHAR_RETURN, CHAR_NEWLINE, "q"};
    tiny    = '{"M", "8", CHAR_NEWLINE, CHAR_BANG};
    huge    = '{"W", "g", "Y", CHAR_NEWLINE, "0"};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: every character class, lower case
    // folding, bytes outside the font, and the all-zero and all-one codes.
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    foreach (opening[i]) send_char(opening[i]);
    park_until_done();

    // Largest scale on the tallest screen. A short run of tabs carries the
    // cursor past the right edge; the glyph after it then has to wrap.
    program_regs(24'h000000, 24'hFFFFFF, 24'd8, 24'd1000, 24'd8191);
    repeat (TAB_RUN) send_char(CHAR_TAB);
    send_char("W");
    send_char(CHAR_RETURN);
    park_until_done();

    // Zero scale and a zero-sized screen, both read as one. Every glyph now
    // wraps and then also scrolls at the bottom, and each scroll band is
    // the whole one-pixel screen.
    program_regs(24'h123456, 24'hABCDEF, 24'd0, 24'd0, 24'd0);
    foreach (tiny[i]) send_char(tiny[i]);
    park_until_done();

    // Scale above the maximum on a screen smaller than one glyph: squares
    // are cut at the right and bottom edges or dropped beyond them.
    program_regs(24'($urandom), 24'($urandom), 24'd15, 24'd36, 24'd30);
    foreach (huge[i]) send_char(huge[i]);
    park_until_done();

    // Random register setups with text-like streams. The second setup holds
    // the output back for a long time while characters keep coming, the
    // third pauses the input halfway until everything has drained, and the
    // last runs with no idling at all.
    for (int p = 0; p < RANDOM_SETUPS; p++) begin
      gaps_on   = (p != RANDOM_SETUPS - 1) && ($urandom_range(0, 4) != 0);
      stalls_on = (p != RANDOM_SETUPS - 1) && ($urandom_range(0, 4) != 0);
      program_regs(24'($urandom), 24'($urandom), pick_scale(), pick_dim(), pick_dim());
      if (p == 1) begin
        long_hold_req = 1'b1;
      end
      run_text(ITEMS_PER_SETUP / 2);
      if (p == 2) begin
        park_until_done();
      end
      run_text(ITEMS_PER_SETUP - ITEMS_PER_SETUP / 2);
      park_until_done();
    end

    $display("Run covered %0d characters over %0d register setups, with random gaps",
             sb.chars_seen, setups);
    $display("and one long output stall; %0d draw commands checked (%0d scrolls, %0d clipped).",
             sb.cmds_checked, sb.scrolls_checked, sb.clipped_planned);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** text_console_glyph_renderer: PASSED **");
    end else begin
      $display("** text_console_glyph_renderer: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/tcgr_pkg.sv
src/tcgr_ctrl.sv
src/tcgr_dp.sv
src/text_console_glyph_renderer.sv
test/tcgr_tb_pkg.sv
test/text_console_glyph_renderer_tb.sv
